// ===== sv/slfp_pkg.sv =====
// Shared types and constants of the sorted list with free pool.
`timescale 1ns / 1ps

package slfp_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int VALUE_W   = 16;
    localparam int STATUS_W  = 2;
    localparam int COUNT_W   = 4;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_DONE = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] ST_MISS = 2'd2;

    // Write enables of the slot store; both share one write address.
    typedef struct packed {
        logic val_we;
        logic link_we;
    } t_slot_wr;

endpackage

// ===== sv/slfp_slots.sv =====
// Slot store: value and link memories with one write and one registered read port.
`timescale 1ns / 1ps

module slfp_slots #(
    parameter int DEPTH = slfp_pkg::DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  slfp_pkg::t_slot_wr                  i_wr,
    input  logic [$clog2(DEPTH)-1:0]            i_wr_addr,
    input  logic signed [slfp_pkg::VALUE_W-1:0] i_wr_value,
    input  logic [$clog2(DEPTH)-1:0]            i_wr_link,
    input  logic [$clog2(DEPTH)-1:0]            i_rd_addr,
    output logic signed [slfp_pkg::VALUE_W-1:0] o_rd_value,
    output logic [$clog2(DEPTH)-1:0]            o_rd_link
);

    localparam int AW = $clog2(DEPTH);

    logic signed [slfp_pkg::VALUE_W-1:0] r_val_mem [DEPTH];
    logic [AW-1:0]                       r_link_mem [DEPTH];
    logic [DEPTH-1:0]                    r_link_vld;
    logic [DEPTH-1:0]                    n_link_vld;

    logic signed [slfp_pkg::VALUE_W-1:0] r_rd_value;
    logic [AW-1:0]                       r_rd_link;
    logic                                r_rd_vld;
    logic [AW-1:0]                       r_rd_addr;

    always_ff @(posedge i_clk) begin
        if (i_wr.val_we) begin
            r_val_mem[i_wr_addr] <= i_wr_value;
        end
        if (i_wr.link_we) begin
            r_link_mem[i_wr_addr] <= i_wr_link;
        end
        r_rd_value <= r_val_mem[i_rd_addr];
        r_rd_link  <= r_link_mem[i_rd_addr];
        r_rd_addr  <= i_rd_addr;
    end

    always_comb begin
        n_link_vld = r_link_vld;
        if (i_wr.link_we) begin
            n_link_vld[i_wr_addr] = 1'b1;
        end
    end

    // A link never written since reset still belongs to the initial free chain.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link_vld <= '0;
            r_rd_vld   <= 1'b0;
        end else begin
            r_link_vld <= n_link_vld;
            r_rd_vld   <= r_link_vld[i_rd_addr];
        end
    end

    assign o_rd_value = r_rd_value;
    assign o_rd_link  = r_rd_vld ? r_rd_link
                      : ((r_rd_addr == AW'(DEPTH - 1)) ? '0 : r_rd_addr + AW'(1));

endmodule

// ===== sv/sorted_list_with_free_pool.sv =====
// Top level: sequencer of the sorted list held in a pool of linked slots.
`timescale 1ns / 1ps

// Keeps an ascending list of signed 16-bit values in DEPTH linked slots, slot 0
// being the null link, so at most DEPTH-1 values are held. An insert takes the
// first free slot and links it at the head, at the tail, or ahead of the first
// held value that is not smaller; a remove frees the head only when it holds
// the given value. Each request gives one result with a status, the count and
// the head value. The block takes one request at a time. An insert that goes
// at the head or into an empty list is settled against the head value, one
// beyond the tail against the tail value, and any other insert walks the list
// from the head, reading one slot a cycle from the single read port of the
// slot store, until a held value that is not smaller or the tail is reached.
// Reset gives an empty list at once, with no clearing pass.
module sorted_list_with_free_pool #(
    parameter int DEPTH = slfp_pkg::DEPTH_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic                                 i_op,
    input  logic signed [slfp_pkg::VALUE_W-1:0]  i_value,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic [slfp_pkg::STATUS_W-1:0]        o_status,
    output logic [slfp_pkg::COUNT_W-1:0]         o_count,
    output logic signed [slfp_pkg::VALUE_W-1:0]  o_head_value
);

    localparam int AW = $clog2(DEPTH);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_INS   = 4'd1;
    localparam logic [3:0] S_TAIL  = 4'd2;
    localparam logic [3:0] S_FIRST = 4'd3;
    localparam logic [3:0] S_WALK  = 4'd4;
    localparam logic [3:0] S_LINK  = 4'd5;
    localparam logic [3:0] S_REM   = 4'd6;
    localparam logic [3:0] S_HVAL  = 4'd7;
    localparam logic [3:0] S_DONE  = 4'd8;

    logic [3:0]                          r_state, n_state;
    logic signed [slfp_pkg::VALUE_W-1:0] r_value, n_value;
    logic [AW-1:0]                       r_head, n_head;
    logic [AW-1:0]                       r_tail, n_tail;
    logic [AW-1:0]                       r_free, n_free;
    logic [AW-1:0]                       r_count, n_count;
    logic signed [slfp_pkg::VALUE_W-1:0] r_head_val, n_head_val;
    logic signed [slfp_pkg::VALUE_W-1:0] r_tail_val, n_tail_val;
    logic [AW-1:0]                       r_new, n_new;
    logic [AW-1:0]                       r_prev, n_prev;
    logic [AW-1:0]                       r_cur, n_cur;
    logic [slfp_pkg::STATUS_W-1:0]       r_status, n_status;

    logic                                r_out_valid, n_out_valid;
    logic [slfp_pkg::STATUS_W-1:0]       r_out_status, n_out_status;
    logic [slfp_pkg::COUNT_W-1:0]        r_out_count, n_out_count;
    logic signed [slfp_pkg::VALUE_W-1:0] r_out_head, n_out_head;

    slfp_pkg::t_slot_wr                  wr;
    logic [AW-1:0]                       wr_addr;
    logic [AW-1:0]                       wr_link;
    logic [AW-1:0]                       rd_addr;
    logic signed [slfp_pkg::VALUE_W-1:0] rd_value;
    logic [AW-1:0]                       rd_link;

    // The one comparator, shared by the head, tail and walk steps.
    logic signed [slfp_pkg::VALUE_W-1:0] cmp_b;
    logic                                gt;

    assign gt = r_value > cmp_b;

    slfp_slots #(
        .DEPTH (DEPTH)
    ) u_slots (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr       (wr),
        .i_wr_addr  (wr_addr),
        .i_wr_value (r_value),
        .i_wr_link  (wr_link),
        .i_rd_addr  (rd_addr),
        .o_rd_value (rd_value),
        .o_rd_link  (rd_link)
    );

    always_comb begin
        n_state      = r_state;
        n_value      = r_value;
        n_head       = r_head;
        n_tail       = r_tail;
        n_free       = r_free;
        n_count      = r_count;
        n_head_val   = r_head_val;
        n_tail_val   = r_tail_val;
        n_new        = r_new;
        n_prev       = r_prev;
        n_cur        = r_cur;
        n_status     = r_status;
        n_out_valid  = r_out_valid;
        n_out_status = r_out_status;
        n_out_count  = r_out_count;
        n_out_head   = r_out_head;
        wr           = '0;
        wr_addr      = r_new;
        wr_link      = '0;
        rd_addr      = r_free;
        cmp_b        = r_head_val;

        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_value = i_value;
                    if (i_op == slfp_pkg::OP_REMOVE) begin
                        rd_addr = r_head;
                        n_state = S_REM;
                    end else begin
                        n_state = S_INS;
                    end
                end
            end
            S_INS: begin
                cmp_b = r_head_val;
                if (r_free == '0) begin
                    n_status = slfp_pkg::ST_FULL;
                    n_state  = S_DONE;
                end else begin
                    // The free slot is taken here whatever place it ends up in.
                    n_new      = r_free;
                    n_free     = rd_link;
                    n_count    = r_count + AW'(1);
                    n_status   = slfp_pkg::ST_DONE;
                    wr.val_we  = 1'b1;
                    wr_addr    = r_free;
                    if (r_head == '0) begin
                        wr.link_we = 1'b1;
                        wr_link    = '0;
                        n_head     = r_free;
                        n_tail     = r_free;
                        n_head_val = r_value;
                        n_tail_val = r_value;
                        n_state    = S_DONE;
                    end else if (!gt) begin
                        wr.link_we = 1'b1;
                        wr_link    = r_head;
                        n_head     = r_free;
                        n_head_val = r_value;
                        n_state    = S_DONE;
                    end else begin
                        n_state = S_TAIL;
                    end
                end
            end
            S_TAIL: begin
                cmp_b = r_tail_val;
                if (gt) begin
                    wr.link_we = 1'b1;
                    wr_addr    = r_new;
                    wr_link    = '0;
                    n_prev     = r_tail;
                    n_tail     = r_new;
                    n_tail_val = r_value;
                    n_state    = S_LINK;
                end else begin
                    n_prev  = r_head;
                    rd_addr = r_head;
                    n_state = S_FIRST;
                end
            end
            S_FIRST: begin
                n_cur   = rd_link;
                rd_addr = rd_link;
                n_state = S_WALK;
            end
            S_WALK: begin
                cmp_b = rd_value;
                if (r_cur != '0 && gt) begin
                    n_prev  = r_cur;
                    n_cur   = rd_link;
                    rd_addr = rd_link;
                end else begin
                    wr.link_we = 1'b1;
                    wr_addr    = r_new;
                    wr_link    = r_cur;
                    if (r_cur == '0) begin
                        n_tail     = r_new;
                        n_tail_val = r_value;
                    end
                    n_state = S_LINK;
                end
            end
            S_LINK: begin
                wr.link_we = 1'b1;
                wr_addr    = r_prev;
                wr_link    = r_new;
                n_state    = S_DONE;
            end
            S_REM: begin
                if (r_head == '0 || r_head_val != r_value) begin
                    n_status = slfp_pkg::ST_MISS;
                    n_state  = S_DONE;
                end else begin
                    // The old head goes back on the front of the free chain.
                    wr.link_we = 1'b1;
                    wr_addr    = r_head;
                    wr_link    = r_free;
                    n_free     = r_head;
                    n_count    = r_count - AW'(1);
                    n_head     = rd_link;
                    n_status   = slfp_pkg::ST_DONE;
                    if (rd_link == '0) begin
                        n_tail     = '0;
                        n_head_val = '0;
                        n_state    = S_DONE;
                    end else begin
                        rd_addr = rd_link;
                        n_state = S_HVAL;
                    end
                end
            end
            S_HVAL: begin
                n_head_val = rd_value;
                n_state    = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_ready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_count  = slfp_pkg::COUNT_W'(r_count);
                    n_out_head   = r_head_val;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_free      <= AW'(1);
            r_count     <= '0;
            r_head_val  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_free      <= n_free;
            r_count     <= n_count;
            r_head_val  <= n_head_val;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value      <= n_value;
        r_tail_val   <= n_tail_val;
        r_new        <= n_new;
        r_prev       <= n_prev;
        r_cur        <= n_cur;
        r_status     <= n_status;
        r_out_status <= n_out_status;
        r_out_count  <= n_out_count;
        r_out_head   <= n_out_head;
    end

    assign o_ready      = (r_state == S_IDLE);
    assign o_valid      = r_out_valid;
    assign o_status     = r_out_status;
    assign o_count      = r_out_count;
    assign o_head_value = r_out_head;

`ifndef SYNTH
    // Between requests the free chain is empty exactly when every slot is held.
    a_free_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> ((r_free == '0) == (r_count == AW'(DEPTH - 1))))
        else $error("free chain and held count disagree");

    // Between requests the list is empty exactly when the count is zero.
    a_head_count : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> ((r_head == '0) == (r_count == '0)))
        else $error("head slot and held count disagree");

    // An empty list must report a head value of zero and hold no tail slot.
    a_empty_head : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && r_head == '0) |-> (r_head_val == '0 && r_tail == '0))
        else $error("empty list keeps a stale head or tail");
`endif

endmodule
